// File: sv/cohist_pkg.sv
// shared constants, types and helpers for the clock offset histogram
package cohist_pkg;

    // histogram geometry
    localparam int HALF_BINS    = 2000;
    localparam int BIN_WIDTH_NS = 100;
    localparam int COUNT_BITS   = 32;

    localparam int NUM_BINS = 2 * HALF_BINS + 1;
    localparam int BIN_AW   = $clog2(NUM_BINS);

    // field widths of the stream items
    localparam int BIN_INDEX_W = 12;
    localparam int SEC_W       = 32;
    localparam int NSEC_W      = 30;
    localparam int TIME_W      = 64;
    localparam int CNT_OUT_W   = 32;
    localparam int LIMIT_W     = 32;
    localparam int SEC_PROD_W  = SEC_W + NSEC_W;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 136;
    localparam int M_PAD_W   = M_TDATA_W - (TIME_W + CNT_OUT_W + 2 + LIMIT_W);

    localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);

    // in-range check and division by the bin width through a reciprocal
    localparam logic [63:0] RANGE_NS = 64'(HALF_BINS + 1) * 64'(BIN_WIDTH_NS);
    localparam int MAG_BITS   = $clog2(RANGE_NS);
    localparam int DIV_SHIFT  = MAG_BITS + $clog2(BIN_WIDTH_NS);
    localparam int RECIP_BITS = MAG_BITS + 1;
    localparam int QPROD_W    = MAG_BITS + RECIP_BITS;
    localparam int Q_W        = $clog2(HALF_BINS + 1);
    localparam logic [RECIP_BITS-1:0] DIV_RECIP = RECIP_BITS'(
        ((64'd1 << DIV_SHIFT) + 64'(BIN_WIDTH_NS) - 64'd1) / 64'(BIN_WIDTH_NS));

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [CNT_OUT_W-1:0]  CNT_OUT_MAX = {CNT_OUT_W{1'b1}};

    // queue between front and back
    localparam int QDEPTH = 8;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int OBUF_DEPTH = 4;
    localparam int OB_AW      = $clog2(OBUF_DEPTH);
    localparam int OBCNT_W    = $clog2(OBUF_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_READ   = 1'b1
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIST_ENABLE  = 1'b0,
        CFG_SAMPLE_LIMIT = 1'b1
    } cfg_reg_t;

    // one classified item on its way from front to back
    typedef struct packed {
        act_t              act;
        logic              idx_ok;
        logic [BIN_AW-1:0] addr;
        logic [TIME_W-1:0] offset;
    } job_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } qstat_t;

    typedef struct packed {
        logic clearing;
    } bstat_t;

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [CNT_OUT_W-1:0] r;
        if (c > COUNT_BITS'(CNT_OUT_MAX)) begin
            r = CNT_OUT_MAX;
        end else begin
            r = CNT_OUT_W'(c);
        end
        return r;
    endfunction

endpackage

// File: sv/cohist_front.sv
// front: accepts beats, forms the offset and the bin address
module cohist_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cohist_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                                s_tuser,
    input  cohist_pkg::qstat_t                  qstat,
    input  cohist_pkg::bstat_t                  bstat,
    output logic                                push,
    output cohist_pkg::job_t                    push_job
);
    import cohist_pkg::*;

    localparam int REF_SEC_LO   = BIN_INDEX_W;
    localparam int REF_NSEC_LO  = REF_SEC_LO + SEC_W;
    localparam int LOC_SEC_LO   = REF_NSEC_LO + NSEC_W;
    localparam int LOC_NSEC_LO  = LOC_SEC_LO + SEC_W;

    logic                   accept;
    logic [QCNT_W:0]        occupancy;
    logic [SEC_PROD_W-1:0]  ref_prod, loc_prod;

    // stage 1
    logic                   s1_valid_reg;
    act_t                   s1_act_reg;
    logic [BIN_INDEX_W-1:0] s1_bidx_reg;
    logic [SEC_PROD_W-1:0]  s1_ref_p_reg, s1_loc_p_reg;
    logic [NSEC_W-1:0]      s1_ref_ns_reg, s1_loc_ns_reg;
    // stage 2
    logic                   s2_valid_reg;
    act_t                   s2_act_reg;
    logic [BIN_AW-1:0]      s2_bidx_reg;
    logic                   s2_bidx_ok_reg;
    logic [TIME_W-1:0]      s2_ref_t_reg, s2_loc_t_reg;
    // stage 3
    logic                   s3_valid_reg;
    act_t                   s3_act_reg;
    logic [BIN_AW-1:0]      s3_bidx_reg;
    logic                   s3_bidx_ok_reg;
    logic [TIME_W-1:0]      s3_off_reg, s3_mag_reg;
    logic                   s3_neg_reg;
    // stage 4
    logic                   s4_valid_reg;
    act_t                   s4_act_reg;
    logic [BIN_AW-1:0]      s4_bidx_reg;
    logic                   s4_bidx_ok_reg;
    logic [TIME_W-1:0]      s4_off_reg;
    logic                   s4_neg_reg;
    logic                   s4_in_rng_reg;
    logic [QPROD_W-1:0]     s4_qprod_reg;

    logic [Q_W-1:0]         quot;
    logic [BIN_AW-1:0]      bin_addr;

    // credit: every item in flight has a queue slot waiting for it
    assign occupancy = (QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(s1_valid_reg)
                     + (QCNT_W+1)'(s2_valid_reg) + (QCNT_W+1)'(s3_valid_reg)
                     + (QCNT_W+1)'(s4_valid_reg);
    assign s_tready = !bstat.clearing && (occupancy < (QCNT_W+1)'(QDEPTH));
    assign accept   = s_tvalid && s_tready;

    assign ref_prod = SEC_PROD_W'(s_tdata[REF_SEC_LO +: SEC_W]) * SEC_PROD_W'(NS_PER_SEC);
    assign loc_prod = SEC_PROD_W'(s_tdata[LOC_SEC_LO +: SEC_W]) * SEC_PROD_W'(NS_PER_SEC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_act_reg    <= act_t'(s_tuser);
        s1_bidx_reg   <= s_tdata[BIN_INDEX_W-1:0];
        s1_ref_p_reg  <= ref_prod;
        s1_loc_p_reg  <= loc_prod;
        s1_ref_ns_reg <= s_tdata[REF_NSEC_LO +: NSEC_W];
        s1_loc_ns_reg <= s_tdata[LOC_NSEC_LO +: NSEC_W];

        s2_act_reg     <= s1_act_reg;
        s2_bidx_reg    <= BIN_AW'(s1_bidx_reg);
        s2_bidx_ok_reg <= 32'(s1_bidx_reg) < 32'(NUM_BINS);
        s2_ref_t_reg   <= TIME_W'(s1_ref_p_reg) + TIME_W'(s1_ref_ns_reg);
        s2_loc_t_reg   <= TIME_W'(s1_loc_p_reg) + TIME_W'(s1_loc_ns_reg);

        s3_act_reg     <= s2_act_reg;
        s3_bidx_reg    <= s2_bidx_reg;
        s3_bidx_ok_reg <= s2_bidx_ok_reg;
        s3_off_reg     <= s2_ref_t_reg - s2_loc_t_reg;
        s3_neg_reg     <= s2_ref_t_reg < s2_loc_t_reg;
        s3_mag_reg     <= (s2_ref_t_reg < s2_loc_t_reg) ? (s2_loc_t_reg - s2_ref_t_reg)
                                                        : (s2_ref_t_reg - s2_loc_t_reg);

        s4_act_reg     <= s3_act_reg;
        s4_bidx_reg    <= s3_bidx_reg;
        s4_bidx_ok_reg <= s3_bidx_ok_reg;
        s4_off_reg     <= s3_off_reg;
        s4_neg_reg     <= s3_neg_reg;
        s4_in_rng_reg  <= s3_mag_reg < RANGE_NS;
        // exact floor division for magnitudes below the range limit
        s4_qprod_reg   <= QPROD_W'(s3_mag_reg[MAG_BITS-1:0]) * QPROD_W'(DIV_RECIP);
    end

    assign quot = s4_qprod_reg[DIV_SHIFT +: Q_W];

    always_comb begin
        if (s4_neg_reg) begin
            bin_addr = BIN_AW'(HALF_BINS) - BIN_AW'(quot);
        end else begin
            bin_addr = BIN_AW'(HALF_BINS) + BIN_AW'(quot);
        end
        push_job.act    = s4_act_reg;
        push_job.offset = s4_off_reg;
        if (s4_act_reg == ACT_READ) begin
            push_job.idx_ok = s4_bidx_ok_reg;
            push_job.addr   = s4_bidx_reg;
        end else begin
            push_job.idx_ok = s4_in_rng_reg;
            push_job.addr   = bin_addr;
        end
    end

    assign push = s4_valid_reg;

endmodule

// File: sv/cohist_queue.sv
// short fifo of classified items between front and back
module cohist_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  cohist_pkg::job_t    push_job,
    input  logic                pop,
    output cohist_pkg::job_t    head_job,
    output cohist_pkg::qstat_t  qstat
);
    import cohist_pkg::*;

    job_t              entries_reg [QDEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job    = entries_reg[rd_ptr_reg];
    assign qstat.count = count_reg;
    assign qstat.empty = (count_reg == '0);

endmodule

// File: sv/cohist_back.sv
// back: run state, bin store read-modify-write and result buffer
module cohist_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cohist_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cohist_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  cohist_pkg::qstat_t                  qstat,
    input  cohist_pkg::job_t                    head_job,
    output logic                                pop,
    output cohist_pkg::bstat_t                  bstat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cohist_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser
);
    import cohist_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0]    offset;
        logic [CNT_OUT_W-1:0] bin_count;
        logic                 skipped;
        logic                 over;
        logic                 done;
        logic [LIMIT_W-1:0]   left;
    } res_t;

    // configuration
    logic                  hist_en_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    // run state
    logic                  warmed_reg, warmed_next;
    logic                  finished_reg, finished_next;
    logic                  range_err_reg, range_err_next;
    logic [LIMIT_W-1:0]    remaining_reg, remaining_next;
    logic [TIME_W-1:0]     last_off_reg, last_off_next;
    logic [LIMIT_W-1:0]    rem_dec;
    logic                  skip, inc, rd;

    // clearing pass
    logic                  clr_active_reg;
    logic [BIN_AW-1:0]     clr_addr_reg;

    // bin store and forwarding of the last write
    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  fwd_valid_reg;
    logic [BIN_AW-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // second back stage
    logic                  b2_valid_reg;
    logic                  b2_inc_reg, b2_rd_reg;
    logic [BIN_AW-1:0]     b2_addr_reg;
    res_t                  b2_res_reg;
    logic [COUNT_BITS-1:0] cnt, cnt_inc;
    logic                  wr;
    res_t                  b2_out;

    // result buffer
    res_t                  obuf_reg [OBUF_DEPTH];
    logic [OB_AW-1:0]      ob_wr_ptr_reg, ob_rd_ptr_reg;
    logic [OBCNT_W-1:0]    ob_cnt_reg;
    logic                  ob_pop;
    logic [OBCNT_W:0]      ob_need;
    res_t                  ob_head;

    assign bstat.clearing = clr_active_reg;

    // a popped item must find room once it leaves the second stage
    assign ob_need = (OBCNT_W+1)'(ob_cnt_reg) + (OBCNT_W+1)'(b2_valid_reg) + (OBCNT_W+1)'(1);
    assign pop = !qstat.empty && !clr_active_reg && (ob_need <= (OBCNT_W+1)'(OBUF_DEPTH));

    always_comb begin
        warmed_next    = warmed_reg;
        finished_next  = finished_reg;
        range_err_next = range_err_reg;
        remaining_next = remaining_reg;
        last_off_next  = last_off_reg;
        skip           = 1'b0;
        inc            = 1'b0;
        rem_dec        = (remaining_reg != '0) ? (remaining_reg - LIMIT_W'(1)) : '0;
        rd             = pop && (head_job.act == ACT_READ) && head_job.idx_ok;
        if (pop && (head_job.act == ACT_SAMPLE)) begin
            if (!warmed_reg) begin
                warmed_next = 1'b1;
                skip        = 1'b1;
            end else if (finished_reg || range_err_reg) begin
                skip = 1'b1;
            end else begin
                last_off_next = head_job.offset;
                if (hist_en_reg) begin
                    if (head_job.idx_ok) begin
                        inc = 1'b1;
                    end else begin
                        range_err_next = 1'b1;
                    end
                end
                if (limit_reg != '0) begin
                    remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        finished_next = 1'b1;
                    end
                end
            end
        end
        // a new limit also reloads the countdown
        if (cfg_we && (cfg_reg_t'(cfg_index) == CFG_SAMPLE_LIMIT)) begin
            remaining_next = LIMIT_W'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_en_reg    <= 1'b0;
            limit_reg      <= '0;
            warmed_reg     <= 1'b0;
            finished_reg   <= 1'b0;
            range_err_reg  <= 1'b0;
            remaining_reg  <= '0;
            last_off_reg   <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_valid_reg  <= 1'b0;
            b2_valid_reg   <= 1'b0;
        end else begin
            warmed_reg    <= warmed_next;
            finished_reg  <= finished_next;
            range_err_reg <= range_err_next;
            remaining_reg <= remaining_next;
            last_off_reg  <= last_off_next;
            b2_valid_reg  <= pop;
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_HIST_ENABLE: begin
                        hist_en_reg <= cfg_wdata[0];
                    end
                    CFG_SAMPLE_LIMIT: begin
                        limit_reg <= LIMIT_W'(cfg_wdata);
                    end
                    default: begin
                    end
                endcase
            end
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + BIN_AW'(1);
                if (clr_addr_reg == BIN_AW'(NUM_BINS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (clr_active_reg) begin
                fwd_valid_reg <= 1'b0;
            end else if (wr) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b2_inc_reg          <= inc;
        b2_rd_reg           <= rd;
        b2_addr_reg         <= head_job.addr;
        b2_res_reg.offset    <= last_off_next;
        b2_res_reg.bin_count <= '0;
        b2_res_reg.skipped   <= skip;
        b2_res_reg.over      <= range_err_next;
        b2_res_reg.done      <= finished_next;
        b2_res_reg.left      <= (limit_reg != '0) ? remaining_next : '0;
        if (wr) begin
            fwd_addr_reg <= b2_addr_reg;
            fwd_data_reg <= cnt_inc;
        end
    end

    // bin store: one read port, one write port
    always_ff @(posedge aclk) begin
        if (pop && head_job.idx_ok) begin
            rdata_reg <= bin_mem[head_job.addr];
        end
        if (clr_active_reg) begin
            bin_mem[clr_addr_reg] <= '0;
        end else if (wr) begin
            bin_mem[b2_addr_reg] <= cnt_inc;
        end
    end

    // the read port misses a write in the same cycle, so take it from the bypass
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == b2_addr_reg)) begin
            cnt = fwd_data_reg;
        end else begin
            cnt = rdata_reg;
        end
        cnt_inc = (cnt == COUNT_MAX) ? cnt : (cnt + COUNT_BITS'(1));
        wr      = b2_valid_reg && b2_inc_reg;
        b2_out  = b2_res_reg;
        b2_out.bin_count = b2_rd_reg ? sat_count(cnt) : '0;
    end

    // result buffer
    assign ob_pop   = m_tvalid && m_tready;
    assign m_tvalid = (ob_cnt_reg != '0);
    assign ob_head  = obuf_reg[ob_rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_wr_ptr_reg <= '0;
            ob_rd_ptr_reg <= '0;
            ob_cnt_reg    <= '0;
        end else begin
            if (b2_valid_reg) begin
                ob_wr_ptr_reg <= ob_wr_ptr_reg + OB_AW'(1);
            end
            if (ob_pop) begin
                ob_rd_ptr_reg <= ob_rd_ptr_reg + OB_AW'(1);
            end
            if (b2_valid_reg && !ob_pop) begin
                ob_cnt_reg <= ob_cnt_reg + OBCNT_W'(1);
            end else if (ob_pop && !b2_valid_reg) begin
                ob_cnt_reg <= ob_cnt_reg - OBCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b2_valid_reg) begin
            obuf_reg[ob_wr_ptr_reg] <= b2_out;
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, ob_head.left, ob_head.done, ob_head.over,
                      ob_head.bin_count, ob_head.offset};
    assign m_tuser = ob_head.skipped;

endmodule

// File: sv/clock_offset_histogram_top.sv
// top level of the clock offset histogram
//
// Takes one beat per clock cycle sustained unless the result stream applies back-pressure,
// and returns one result beat per input beat, in order. A beat passes through the front
// (seconds-to-nanoseconds multiply, add, subtract for offset and magnitude, reciprocal
// multiply for the bin), the eight-entry queue and the back, where the bin store is read
// as the item leaves the queue and written in the cycle after; a bypass of the last write
// lets increments to the same bin run every cycle, so that read-modify-write loop sets the
// one-beat-per-cycle rate. After reset the bin store is cleared one entry per cycle, during
// which s_tready stays low; configuration writes are taken at any time, but are meant for
// when no beat is in flight.
module clock_offset_histogram_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config
    input  logic                                cfg_we,
    input  logic [cohist_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cohist_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // bin_index, ref_sec, ref_nsec, local_sec, local_nsec
    input  logic [cohist_pkg::S_TDATA_W-1:0]    s_tdata,
    // action
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // offset_ns, bin_count, over_range, run_done, samples_left, zero pad
    output logic [cohist_pkg::M_TDATA_W-1:0]    m_tdata,
    // sample_skipped
    output logic                                m_tuser
);
    import cohist_pkg::*;

    logic   push, pop;
    job_t   push_job, head_job;
    qstat_t qstat;
    bstat_t bstat;

    cohist_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat),
        .bstat    (bstat),
        .push     (push),
        .push_job (push_job)
    );

    cohist_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    cohist_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .head_job  (head_job),
        .pop       (pop),
        .bstat     (bstat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: test/cohist_checker.sv
// result checker for the clock offset histogram: tracks the histogram state and checks each result beat
`timescale 1ns / 100ps

module cohist_checker
    import cohist_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    output int                    errors,
    output int                    pending
);

    localparam logic [63:0] NS_IN_SEC = 64'd1000000000;

    typedef struct packed {
        logic [TIME_W-1:0]    offset_ns;
        logic [CNT_OUT_W-1:0] bin_count;
        logic                 skipped;
        logic                 over_range;
        logic                 run_done;
        logic [LIMIT_W-1:0]   samples_left;
    } report_t;

    // mirrored block state
    logic               hist_on;
    logic [LIMIT_W-1:0] limit_reg;
    logic               seen_first;
    logic [LIMIT_W-1:0] left_count;
    logic               range_hit;
    logic               limit_reached;
    logic [TIME_W-1:0]  last_off;
    logic [COUNT_BITS-1:0] bin_counts [0:NUM_BINS-1];

    report_t expected_reports [$];

    function automatic report_t histogram_step(input act_t act, input logic [S_TDATA_W-1:0] item);
        report_t     r;
        logic [63:0] ref_ns;
        logic [63:0] loc_ns;
        logic [63:0] mag;
        logic [63:0] quot;
        logic        behind;
        int          slot;
        r = '0;
        if (act == ACT_READ) begin
            slot = int'(item[11:0]);
            if (slot < NUM_BINS) begin
                r.bin_count = CNT_OUT_W'(bin_counts[slot]);
            end
        end else if (!seen_first) begin
            // warm-up beat
            seen_first = 1'b1;
            r.skipped  = 1'b1;
        end else if (limit_reached || range_hit) begin
            r.skipped = 1'b1;
        end else begin
            ref_ns   = 64'(item[43:12]) * NS_IN_SEC + 64'(item[73:44]);
            loc_ns   = 64'(item[105:74]) * NS_IN_SEC + 64'(item[135:106]);
            last_off = ref_ns - loc_ns;
            behind   = ref_ns < loc_ns;
            mag      = behind ? loc_ns - ref_ns : ref_ns - loc_ns;
            if (hist_on) begin
                quot = mag / 64'(BIN_WIDTH_NS);
                if (quot <= 64'(HALF_BINS)) begin
                    slot = behind ? HALF_BINS - int'(quot) : HALF_BINS + int'(quot);
                    if (bin_counts[slot] != COUNT_MAX) begin
                        bin_counts[slot] = bin_counts[slot] + 1'b1;
                    end
                end else begin
                    range_hit = 1'b1;
                end
            end
            if (limit_reg != 0) begin
                if (left_count != 0) begin
                    left_count = left_count - 1'b1;
                end
                if (left_count == 0) begin
                    limit_reached = 1'b1;
                end
            end
        end
        r.offset_ns    = last_off;
        r.over_range   = range_hit;
        r.run_done     = limit_reached;
        r.samples_left = (limit_reg != 0) ? left_count : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        report_t want;
        report_t got;
        if (!aresetn) begin
            hist_on       = 1'b0;
            limit_reg     = '0;
            seen_first    = 1'b0;
            left_count    = '0;
            range_hit     = 1'b0;
            limit_reached = 1'b0;
            last_off      = '0;
            for (int i = 0; i < NUM_BINS; i++) begin
                bin_counts[i] = '0;
            end
            expected_reports.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.offset_ns    = m_tdata[63:0];
                got.bin_count    = m_tdata[95:64];
                got.over_range   = m_tdata[96];
                got.run_done     = m_tdata[97];
                got.samples_left = m_tdata[129:98];
                got.skipped      = m_tuser;
                if (expected_reports.size() == 0) begin
                    $error("result beat with no sample or read waiting for it");
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("offset_ns", want.offset_ns, got.offset_ns);
                    check_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
                    check_field("sample_skipped", 64'(want.skipped), 64'(got.skipped));
                    check_field("over_range", 64'(want.over_range), 64'(got.over_range));
                    check_field("run_done", 64'(want.run_done), 64'(got.run_done));
                    check_field("samples_left", 64'(want.samples_left),
                                64'(got.samples_left));
                end
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_HIST_ENABLE: begin
                        hist_on = cfg_wdata[0];
                    end
                    CFG_SAMPLE_LIMIT: begin
                        // a new limit also reloads the countdown
                        limit_reg  = cfg_wdata;
                        left_count = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(histogram_step(act_t'(s_tuser), s_tdata));
            end
            pending = expected_reports.size();
        end
    end

endmodule

// File: test/tb.sv
// testbench top for the clock offset histogram: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import cohist_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 125;

    localparam logic [63:0] NS_IN_SEC = 64'd1000000000;

    // receiver stall patterns
    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_RUNS   = 2;
    localparam int RX_SPARSE = 3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int burst_left;
    int burst_max;
    int gap_max;
    int rx_mode;
    int run_left = 0;
    logic rx_level = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    clock_offset_histogram_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cohist_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    // watchdog: cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
            repeat ($urandom_range(40, 300)) begin
                @(negedge aclk);
                case (rx_mode)
                    RX_ALWAYS: begin
                        m_tready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    RX_RUNS: begin
                        if (run_left == 0) begin
                            rx_level = !rx_level;
                            run_left = $urandom_range(1, 12);
                        end
                        run_left--;
                        m_tready <= rx_level;
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    function automatic logic [31:0] random_sec();
        return $urandom_range(1, 32'hFFFF_FFFE);
    endfunction

    task automatic send_beat(input act_t act, input logic [11:0] idx,
                             input logic [31:0] rs, input logic [29:0] rn,
                             input logic [31:0] ls, input logic [29:0] ln);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {ln, ls, rn, rs, idx};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gap_max > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge aclk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    // local time built from the reference time minus the wanted offset
    task automatic send_offset(input logic [31:0] rs, input logic [29:0] rn, input longint d);
        logic [63:0] loc_ns;
        logic [31:0] ls;
        logic [29:0] ln;
        loc_ns = 64'(rs) * NS_IN_SEC + 64'(rn) - 64'(d);
        ls     = 32'(loc_ns / NS_IN_SEC);
        ln     = 30'(loc_ns % NS_IN_SEC);
        // same instant written with nanoseconds past one second
        if (ls != 0 && ln < 30'd73741824 && $urandom_range(0, 3) == 0) begin
            ls = ls - 1'b1;
            ln = ln + 30'd1000000000;
        end
        send_beat(ACT_SAMPLE, 12'($urandom), rs, rn, ls, ln);
    endtask

    task automatic read_bin(input int b);
        send_beat(ACT_READ, 12'(b), $urandom, 30'($urandom), $urandom, 30'($urandom));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_beat(input logic hist);
        int          pick;
        longint      d;
        logic [29:0] rn;
        pick = $urandom_range(0, 99);
        rn   = ($urandom_range(0, 9) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
        if (pick < 25) begin
            if (pick < 17) begin
                read_bin(HALF_BINS - 10 + int'($urandom_range(0, 20)));
            end else if (pick < 22) begin
                read_bin($urandom_range(0, NUM_BINS - 1));
            end else begin
                read_bin($urandom_range(0, 4095));
            end
        end else if (!hist) begin
            if (pick < 60) begin
                send_beat(ACT_SAMPLE, 12'($urandom), $urandom, 30'($urandom),
                          $urandom, 30'($urandom));
            end else begin
                send_offset(random_sec(), rn, longint'($urandom_range(0, 2000000)) - 1000000);
            end
        end else begin
            if (pick < 75) begin
                d = longint'($urandom_range(0, 2000)) - 1000;
            end else if (pick < 90) begin
                d = longint'($urandom_range(0, 400198)) - 200099;
            end else begin
                // edge bins
                d = $urandom_range(200000, 200099);
                if ($urandom_range(0, 1) == 1) begin
                    d = -d;
                end
            end
            send_offset(random_sec(), rn, d);
        end
    endtask

    initial begin
        logic        hist;
        logic [31:0] limit;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        burst_left = 0;
        burst_max  = 4;
        gap_max    = 3;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: histogram off, extremes of the timestamps
        write_reg(CFG_HIST_ENABLE, 32'd0);
        write_reg(CFG_SAMPLE_LIMIT, 32'd0);
        read_bin(0);
        send_offset(random_sec(), 30'd123, 0);
        send_beat(ACT_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd0, 30'd0);
        send_beat(ACT_SAMPLE, 12'd0, 32'd0, 30'd0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_beat(ACT_SAMPLE, 12'd7, 32'h1234_5678, 30'd999999999, 32'h1234_5678, 30'd999999999);
        read_bin(4095);
        read_bin(NUM_BINS);
        read_bin(NUM_BINS - 1);

        // directed: histogram on, bin edges both sides of zero
        settle();
        write_reg(CFG_HIST_ENABLE, 32'd1);
        send_offset(random_sec(), 30'd0, 0);
        send_offset(random_sec(), 30'd999999999, 99);
        send_offset(random_sec(), 30'd5, -99);
        send_offset(random_sec(), 30'd400, 100);
        send_offset(random_sec(), 30'd77, -100);
        send_offset(random_sec(), 30'd1, 200099);
        send_offset(random_sec(), 30'd999999000, -200099);
        send_offset(random_sec(), 30'd0, 200000);
        read_bin(HALF_BINS);
        read_bin(HALF_BINS + 1);
        read_bin(HALF_BINS - 1);
        read_bin(NUM_BINS - 1);
        read_bin(0);

        for (int p = 0; p < PHASES; p++) begin
            hist = (p % 4 != 1);
            case (p % 4)
                0: limit = 32'hFFFF_FFFF;
                1: limit = 32'd0;
                2: limit = $urandom_range(PHASE_BEATS + 1, 100000);
                default: limit = $urandom_range(32'h8000_0000, 32'hFFFF_FFFE);
            endcase
            case (p % 3)
                0: begin
                    gap_max   = 0;
                    burst_max = 0;
                end
                1: begin
                    gap_max   = 3;
                    burst_max = 2;
                end
                default: begin
                    gap_max   = 12;
                    burst_max = 20;
                end
            endcase
            settle();
            write_reg(CFG_HIST_ENABLE, 32'(hist));
            write_reg(CFG_SAMPLE_LIMIT, limit);
            repeat (PHASE_BEATS) random_beat(hist);
        end

        // countdown, then out of range on the last counted sample
        gap_max   = 3;
        burst_max = 4;
        settle();
        write_reg(CFG_HIST_ENABLE, 32'd1);
        write_reg(CFG_SAMPLE_LIMIT, 32'd3);
        send_offset(random_sec(), 30'd5, 5);
        send_offset(random_sec(), 30'd999, -700);
        settle();
        write_reg(CFG_SAMPLE_LIMIT, 32'd1);
        send_offset(random_sec(), 30'd31, 200100);
        send_offset(random_sec(), 30'd0, 0);
        send_beat(ACT_SAMPLE, 12'($urandom), $urandom, 30'($urandom), $urandom, 30'($urandom));
        // reload after stop: flags stay set
        settle();
        write_reg(CFG_SAMPLE_LIMIT, 32'd7);
        send_offset(random_sec(), 30'd8, 42);
        settle();
        write_reg(CFG_HIST_ENABLE, 32'd0);
        write_reg(CFG_SAMPLE_LIMIT, 32'd0);
        send_offset(random_sec(), 30'd9, -42);
        repeat (30) read_bin(HALF_BINS - 15 + int'($urandom_range(0, 30)));
        read_bin(HALF_BINS - 7);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/cohist_pkg.sv
sv/cohist_front.sv
sv/cohist_queue.sv
sv/cohist_back.sv
sv/clock_offset_histogram_top.sv
test/cohist_checker.sv
test/tb.sv
